/* rtl/pwmd_pkg.sv */
// ----------------------------------------------------------------------------
// pwmd_pkg
// Shared types and constants for the PWM divider / level calculator.
// ----------------------------------------------------------------------------
package pwmd_pkg;

  localparam int FREQ_W   = 30;
  localparam int DUTY_W   = 7;
  localparam int OUT_W    = 16;
  localparam int RANGE_W  = 16;
  localparam int PROD_W   = FREQ_W + RANGE_W;
  localparam int LEVEL_W  = OUT_W + 1 + DUTY_W;
  localparam int RECIP_W  = 24;
  localparam int SCALED_W = LEVEL_W + RECIP_W;

  localparam int COUNTER_RANGE_DEF = 65534;
  localparam logic [FREQ_W-1:0] CLOCK_RESET = FREQ_W'(125000000);
  localparam logic [DUTY_W-1:0] FULL_DUTY   = DUTY_W'(100);
  localparam logic [OUT_W-1:0]  MAX16       = '1;

  // floor(x/100) == (x * RECIP_100) >> RECIP_SHIFT for x < 2^30/76
  localparam logic [RECIP_W-1:0] RECIP_100   = RECIP_W'(10737419);
  localparam int                 RECIP_SHIFT = 30;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = 1;

  typedef struct packed {
    logic              bad;
    logic [FREQ_W-1:0] freq;
    logic [DUTY_W-1:0] duty;
    logic [PROD_W-1:0] prod;
  } item_t;

  typedef struct packed {
    logic              bad;
    logic [FREQ_W-1:0] freq;
    logic [DUTY_W-1:0] duty;
  } side1_t;

  typedef struct packed {
    logic              bad;
    logic [DUTY_W-1:0] duty;
    logic [OUT_W-1:0]  div;
  } side2_t;

endpackage

/* rtl/pwmd_front.sv */
// ----------------------------------------------------------------------------
// pwmd_front
// Accepts requests, flags bad ones, saturates duty, forms freq * range.
// ----------------------------------------------------------------------------
module pwmd_front #(
  parameter int COUNTER_RANGE = pwmd_pkg::COUNTER_RANGE_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [pwmd_pkg::FREQ_W-1:0] freq_hz,
  input  logic [pwmd_pkg::DUTY_W-1:0] duty_percent,
  input  logic [pwmd_pkg::FREQ_W-1:0] clock_hz,
  input  logic                        q_full,
  output logic                        push,
  output pwmd_pkg::item_t             push_item
);

  localparam logic [pwmd_pkg::RANGE_W-1:0] RANGE = pwmd_pkg::RANGE_W'(COUNTER_RANGE);

  logic            front_valid;
  pwmd_pkg::item_t item;

  assign in_stall  = front_valid && q_full;
  assign push      = front_valid && !q_full;
  assign push_item = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (!in_stall) begin
      front_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item.bad  <= (freq_hz == '0) || (freq_hz > clock_hz);
      item.freq <= freq_hz;
      item.duty <= (duty_percent > pwmd_pkg::FULL_DUTY) ? pwmd_pkg::FULL_DUTY : duty_percent;
      item.prod <= pwmd_pkg::PROD_W'(freq_hz) * pwmd_pkg::PROD_W'(RANGE);
    end
  end

endmodule

/* rtl/pwmd_queue.sv */
// ----------------------------------------------------------------------------
// pwmd_queue
// Short FIFO between the front and the back.
// ----------------------------------------------------------------------------
module pwmd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  pwmd_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output pwmd_pkg::item_t head_item,
  output logic [pwmd_pkg::QUEUE_AW:0] count
);

  pwmd_pkg::item_t                  entries [pwmd_pkg::QUEUE_DEPTH];
  logic [pwmd_pkg::QUEUE_AW-1:0]    wr_ptr;
  logic [pwmd_pkg::QUEUE_AW-1:0]    rd_ptr;
  logic                             do_pop;

  assign full       = (count == (pwmd_pkg::QUEUE_AW + 1)'(pwmd_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = entries[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_item;
  end

endmodule

/* rtl/pwmd_div.sv */
// ----------------------------------------------------------------------------
// pwmd_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module pwmd_div #(
  parameter int DW = 30,
  parameter int VW = 46,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [DW-1:0] quotient,
  output logic [SW-1:0] side_out
);

  logic [VW-1:0] rem_r [DW];
  logic [DW-1:0] dvd_r [DW];
  logic [DW-1:0] quo_r [DW];
  logic [VW-1:0] dsr_r [DW];
  logic [SW-1:0] sid_r [DW];
  logic          vld_r [DW];

  for (genvar g = 0; g < DW; g++) begin : g_stage
    logic [VW-1:0] p_rem;
    logic [DW-1:0] p_dvd;
    logic [DW-1:0] p_quo;
    logic [VW-1:0] p_dsr;
    logic [SW-1:0] p_sid;
    logic          p_vld;
    logic [VW-1:0] r_sh;
    logic          ge;

    if (g == 0) begin : g_first
      assign p_rem = '0;
      assign p_dvd = dividend;
      assign p_quo = '0;
      assign p_dsr = divisor;
      assign p_sid = side_in;
      assign p_vld = in_valid;
    end else begin : g_next
      assign p_rem = rem_r[g-1];
      assign p_dvd = dvd_r[g-1];
      assign p_quo = quo_r[g-1];
      assign p_dsr = dsr_r[g-1];
      assign p_sid = sid_r[g-1];
      assign p_vld = vld_r[g-1];
    end

    assign r_sh = {p_rem[VW-2:0], p_dvd[DW-1]};
    assign ge   = (r_sh >= p_dsr);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= ge ? (r_sh - p_dsr) : r_sh;
        dvd_r[g] <= {p_dvd[DW-2:0], 1'b0};
        quo_r[g] <= {p_quo[DW-2:0], ge};
        dsr_r[g] <= p_dsr;
        sid_r[g] <= p_sid;
      end
    end
  end

  assign out_valid = vld_r[DW-1];
  assign quotient  = quo_r[DW-1];
  assign side_out  = sid_r[DW-1];

endmodule

/* rtl/pwmd_back.sv */
// ----------------------------------------------------------------------------
// pwmd_back
// Divider, wrap and level pipeline with the output register.
// ----------------------------------------------------------------------------
module pwmd_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  pwmd_pkg::item_t             q_item,
  output logic                        pop,
  input  logic [pwmd_pkg::FREQ_W-1:0] clock_hz,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pwmd_pkg::OUT_W-1:0]  divider,
  output logic [pwmd_pkg::OUT_W-1:0]  wrap_value,
  output logic [pwmd_pkg::OUT_W-1:0]  compare_level,
  output logic                        bad_request
);

  localparam int FW = pwmd_pkg::FREQ_W;
  localparam int OW = pwmd_pkg::OUT_W;

  logic en;
  assign en  = !out_valid || !out_stall;
  assign pop = en && q_valid;

  // first divide: clock / (freq * range)
  pwmd_pkg::side1_t s1_in, s1_out;
  logic             d1_valid;
  logic [FW-1:0]    q1;

  assign s1_in = '{bad: q_item.bad, freq: q_item.freq, duty: q_item.duty};

  pwmd_div #(.DW(FW), .VW(pwmd_pkg::PROD_W), .SW($bits(pwmd_pkg::side1_t))) u_div1 (
    .clk(clk), .rst(rst), .en(en), .in_valid(pop),
    .dividend(clock_hz), .divisor(q_item.prod), .side_in(s1_in),
    .out_valid(d1_valid), .quotient(q1), .side_out(s1_out)
  );

  logic             a_valid;
  pwmd_pkg::side1_t a_side;
  logic [OW-1:0]    a_div;
  logic [FW:0]      q1_inc;
  assign q1_inc = {1'b0, q1} + (FW + 1)'(1);

  logic             b_valid;
  pwmd_pkg::side2_t b_side;
  logic [pwmd_pkg::PROD_W-1:0] b_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else if (en) begin
      a_valid <= d1_valid;
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_side <= s1_out;
      a_div  <= (|q1_inc[FW:OW]) ? pwmd_pkg::MAX16 : q1_inc[OW-1:0];
      b_side <= '{bad: a_side.bad, duty: a_side.duty, div: a_div};
      b_prod <= pwmd_pkg::PROD_W'(a_side.freq) * pwmd_pkg::PROD_W'(a_div);
    end
  end

  // second divide: clock / (freq * divider)
  pwmd_pkg::side2_t s2_out;
  logic             d2_valid;
  logic [FW-1:0]    cycles;

  pwmd_div #(.DW(FW), .VW(pwmd_pkg::PROD_W), .SW($bits(pwmd_pkg::side2_t))) u_div2 (
    .clk(clk), .rst(rst), .en(en), .in_valid(b_valid),
    .dividend(clock_hz), .divisor(b_prod), .side_in(b_side),
    .out_valid(d2_valid), .quotient(cycles), .side_out(s2_out)
  );

  logic [FW-1:0] cyc_m1;
  assign cyc_m1 = (cycles == '0) ? '0 : cycles - FW'(1);

  logic                         c_valid, e_valid, f_valid;
  pwmd_pkg::side2_t             c_side, e_side, f_side;
  logic [OW-1:0]                c_wrap, e_wrap, f_wrap;
  logic [pwmd_pkg::LEVEL_W-1:0] e_prod;
  logic [pwmd_pkg::SCALED_W-1:0] f_scaled;
  logic [OW:0]                  c_wrap_inc;
  logic [OW:0]                  f_level;

  assign c_wrap_inc = {1'b0, c_wrap} + (OW + 1)'(1);
  assign f_level    = f_scaled[pwmd_pkg::RECIP_SHIFT +: OW + 1];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid   <= 1'b0;
      e_valid   <= 1'b0;
      f_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      c_valid   <= d2_valid;
      e_valid   <= c_valid;
      f_valid   <= e_valid;
      out_valid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_side   <= s2_out;
      c_wrap   <= (|cyc_m1[FW-1:OW]) ? pwmd_pkg::MAX16 : cyc_m1[OW-1:0];
      e_side   <= c_side;
      e_wrap   <= c_wrap;
      e_prod   <= pwmd_pkg::LEVEL_W'(c_wrap_inc) * pwmd_pkg::LEVEL_W'(c_side.duty);
      f_side   <= e_side;
      f_wrap   <= e_wrap;
      f_scaled <= pwmd_pkg::SCALED_W'(e_prod) * pwmd_pkg::SCALED_W'(pwmd_pkg::RECIP_100);
      // rejected requests report zero divider, wrap value and compare level
      bad_request   <= f_side.bad;
      divider       <= f_side.bad ? '0 : f_side.div;
      wrap_value    <= f_side.bad ? '0 : f_wrap;
      compare_level <= f_side.bad ? '0 :
                       (f_level[OW] ? pwmd_pkg::MAX16 : f_level[OW-1:0]);
    end
  end

endmodule

/* rtl/pwm_wrap_divider_level_calc.sv */
// ----------------------------------------------------------------------------
// pwm_wrap_divider_level_calc
// PWM clock divider, wrap and compare level from frequency and duty.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries freq_hz and duty_percent; a
//   transfer happens when in_valid is high and in_stall is low. Each request
//   gives one result on the output channel (out_valid / out_stall) with
//   divider, wrap_value, compare_level and bad_request.
//   clock_hz is written through cfg_valid / cfg_data; cfg_ready is always
//   high. Write it only while no request is in flight.
// Timing:
//   One request per cycle sustained while out_stall is low. The path from
//   input transfer to out_valid runs through one front stage, the queue, two
//   30-stage dividers with one quotient bit per stage, the divider and level
//   multiplies and the reciprocal divide by 100.
// Reset: empties the queue and pipeline, clock_hz returns to 125 MHz.
// Stall: out_stall with out_valid high freezes the back pipeline; the two-entry queue and the
//   front stage keep taking requests until the queue fills.
// ----------------------------------------------------------------------------
module pwm_wrap_divider_level_calc #(
  parameter int COUNTER_RANGE = pwmd_pkg::COUNTER_RANGE_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [pwmd_pkg::FREQ_W-1:0] freq_hz,
  input  logic [pwmd_pkg::DUTY_W-1:0] duty_percent,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pwmd_pkg::OUT_W-1:0]  divider,
  output logic [pwmd_pkg::OUT_W-1:0]  wrap_value,
  output logic [pwmd_pkg::OUT_W-1:0]  compare_level,
  output logic                        bad_request,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [pwmd_pkg::FREQ_W-1:0] cfg_data
);

  logic [pwmd_pkg::FREQ_W-1:0] clock_hz;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz <= pwmd_pkg::CLOCK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      clock_hz <= cfg_data;
    end
  end

  logic                        q_full, push, pop, head_valid;
  pwmd_pkg::item_t             push_item, head_item;
  logic [pwmd_pkg::QUEUE_AW:0] q_count;

  pwmd_front #(.COUNTER_RANGE(COUNTER_RANGE)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .freq_hz(freq_hz), .duty_percent(duty_percent), .clock_hz(clock_hz),
    .q_full(q_full), .push(push), .push_item(push_item)
  );

  pwmd_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_item(push_item), .full(q_full),
    .pop(pop), .head_valid(head_valid), .head_item(head_item), .count(q_count)
  );

  pwmd_back u_back (
    .clk(clk), .rst(rst), .q_valid(head_valid), .q_item(head_item), .pop(pop),
    .clock_hz(clock_hz), .out_valid(out_valid), .out_stall(out_stall),
    .divider(divider), .wrap_value(wrap_value), .compare_level(compare_level),
    .bad_request(bad_request)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= (pwmd_pkg::QUEUE_AW + 1)'(pwmd_pkg::QUEUE_DEPTH))
    else $error("queue count over depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_full && !pop |-> !push)
    else $error("push into full queue");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_request |-> divider == '0 && wrap_value == '0 && compare_level == '0)
    else $error("rejected request with nonzero result");

  a_good_div: assert property (@(posedge clk) disable iff (rst)
    out_valid && !bad_request |-> divider != '0 &&
      {1'b0, compare_level} <= {1'b0, wrap_value} + 17'd1)
    else $error("divider zero or level above period");

endmodule

/* dv/pwm_wrap_divider_level_calc_test.sv */
// ----------------------------------------------------------------------------
// pwm_wrap_divider_level_calc_test
// Self-checking bench: drives frequency/duty requests with random gaps and
// receiver stalls, predicts divider, wrap and compare level per request and
// compares each result in order. Several clock settings are exercised.
// ----------------------------------------------------------------------------
module pwm_wrap_divider_level_calc_test;

  localparam int RANGE = pwmd_pkg::COUNTER_RANGE_DEF;
  localparam int DRAIN_CYCLES = 100;

  typedef struct packed {
    logic [pwmd_pkg::OUT_W-1:0] div;
    logic [pwmd_pkg::OUT_W-1:0] wrap;
    logic [pwmd_pkg::OUT_W-1:0] level;
    logic                       bad;
  } pwm_setting_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [pwmd_pkg::FREQ_W-1:0] freq_hz = '0;
  logic [pwmd_pkg::DUTY_W-1:0] duty_percent = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [pwmd_pkg::OUT_W-1:0] divider, wrap_value, compare_level;
  logic bad_request;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [pwmd_pkg::FREQ_W-1:0] cfg_data = '0;

  logic [pwmd_pkg::FREQ_W-1:0] clock_setting;
  pwm_setting_t settings_due[$];
  int errors = 0;
  bit hold_off = 0;
  bit stall_random = 1;

  pwm_wrap_divider_level_calc dut (.*);

  always #5 clk = ~clk;

  function automatic pwm_setting_t calc_setting(logic [pwmd_pkg::FREQ_W-1:0] f,
                                                logic [pwmd_pkg::DUTY_W-1:0] d);
    pwm_setting_t s;
    logic [63:0] clk64, div, cyc, wrap, lvl, duty;
    s = '0;
    clk64 = 64'(clock_setting);
    if (f == 0 || f > clock_setting) begin
      s.bad = 1;
      return s;
    end
    duty = (d > pwmd_pkg::FULL_DUTY) ? 64'(pwmd_pkg::FULL_DUTY) : 64'(d);
    div = clk64 / (64'(f) * 64'(RANGE)) + 64'd1;
    if (div > 65535) div = 65535;
    cyc = clk64 / (64'(f) * div);
    wrap = (cyc > 0) ? cyc - 64'd1 : 64'd0;
    if (wrap > 65535) wrap = 65535;
    lvl = ((wrap + 64'd1) * duty) / 64'd100;
    if (lvl > 65535) lvl = 65535;
    s.div = div[15:0];
    s.wrap = wrap[15:0];
    s.level = lvl[15:0];
    return s;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_request(logic [pwmd_pkg::FREQ_W-1:0] f,
                              logic [pwmd_pkg::DUTY_W-1:0] d, bit gaps = 1);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    freq_hz <= f;
    duty_percent <= d;
    settings_due.push_back(calc_setting(f, d));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // receiver stall
  always @(posedge clk) begin
    if (hold_off) out_stall <= 1;
    else if (stall_random) out_stall <= ($urandom_range(0, 99) < 25);
    else out_stall <= 0;
  end

  // result checker
  always @(posedge clk) begin
    pwm_setting_t e;
    if (!rst && out_valid && !out_stall) begin
      if (settings_due.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        e = settings_due.pop_front();
        if (divider !== e.div) begin
          $error("divider exp %0d got %0d", e.div, divider); errors++;
        end
        if (wrap_value !== e.wrap) begin
          $error("wrap_value exp %0d got %0d", e.wrap, wrap_value); errors++;
        end
        if (compare_level !== e.level) begin
          $error("compare_level exp %0d got %0d", e.level, compare_level); errors++;
        end
        if (bad_request !== e.bad) begin
          $error("bad_request exp %0d got %0d", e.bad, bad_request); errors++;
        end
      end
    end
  end

  task automatic drain();
    in_valid <= 0;
    while (settings_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_clock(logic [pwmd_pkg::FREQ_W-1:0] v);
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    clock_setting = v;
  endtask

  function automatic logic [pwmd_pkg::FREQ_W-1:0] rand_freq();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return pwmd_pkg::FREQ_W'($urandom);  // full width, often above clock
    if (r < 40) return pwmd_pkg::FREQ_W'($urandom_range(1, 5000));
    if (r < 70) return pwmd_pkg::FREQ_W'($urandom_range(1, 2000000));
    if (clock_setting == 0) return pwmd_pkg::FREQ_W'($urandom_range(1, 100));
    return pwmd_pkg::FREQ_W'($urandom_range(1, clock_setting));
  endfunction

  task automatic test_directed();
    send_request(0, 50);
    send_request(1, 0);
    send_request(1, 100);
    send_request(1, 127);
    send_request(clock_setting, 50);
    send_request(pwmd_pkg::FREQ_W'(clock_setting + 1), 50);
    send_request('1, 127);
    send_request(1907, 33);
    send_request(1908, 101);
    send_request(pwmd_pkg::FREQ_W'(clock_setting / 65534), 75);
    send_request(1000, 64);
    send_request(30'h2AAAAAAA, 85);
    send_request(30'h15555555, 42);
    send_request(440, 1);
    drain();
  endtask

  task automatic test_random(int n);
    repeat (n) send_request(rand_freq(), 7'($urandom));
    drain();
  endtask

  task automatic test_fill_up();
    int k;
    fork
      begin
        hold_off = 1;
        for (k = 0; k < 150; k++) @(posedge clk);
        hold_off = 0;
      end
      repeat (100) send_request(rand_freq(), 7'($urandom), 0);
    join
    drain();
  endtask

  task automatic test_clock_settings();
    write_clock(1);
    test_random(40);
    write_clock(0);
    send_request(0, 10);
    send_request(1, 10);
    test_random(30);
    write_clock(30'd1000000000);
    test_random(200);
    write_clock(30'h3FFFFFFF);
    send_request(1, 100);
    test_random(100);
    write_clock(30'd65534);
    send_request(1, 100);
    test_random(60);
    write_clock(pwmd_pkg::CLOCK_RESET);
  endtask

  initial begin
    clock_setting = pwmd_pkg::CLOCK_RESET;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_fill_up();
    test_random(800);
    test_clock_settings();
    stall_random = 0;
    test_random(150);
    stall_random = 1;
    test_random(100);
    if (errors == 0 && settings_due.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
